[hdl/matrix3x3_inverse_top_macros.svh]
// assertion helpers for the 3x3 inverse block
`ifndef MATRIX3X3_INVERSE_TOP_MACROS_SVH
`define MATRIX3X3_INVERSE_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, quiet while rst is high
`define MI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/mi3inv_pkg.sv]
`default_nettype none
package mi3inv_pkg;
  localparam int NUM_ELEM = 9;
  typedef logic [3:0] idx_t;
  // cofactor k = e[a]*e[b] - e[c]*e[d], row-major adjugate order
  localparam idx_t COF_IDX [NUM_ELEM][4] = '{
    '{4'd4, 4'd8, 4'd5, 4'd7}, '{4'd2, 4'd7, 4'd1, 4'd8}, '{4'd1, 4'd5, 4'd2, 4'd4},
    '{4'd5, 4'd6, 4'd3, 4'd8}, '{4'd0, 4'd8, 4'd2, 4'd6}, '{4'd2, 4'd3, 4'd0, 4'd5},
    '{4'd3, 4'd7, 4'd4, 4'd6}, '{4'd1, 4'd6, 4'd0, 4'd7}, '{4'd0, 4'd4, 4'd1, 4'd3}
  };
  // determinant along row 0: e0*c0 + e1*c3 + e2*c6
  localparam idx_t DET_COF [3] = '{4'd0, 4'd3, 4'd6};
endpackage
`default_nettype wire

[hdl/mi3inv_cof.sv]
`default_nettype none
module mi3inv_cof #(
  parameter int EW = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  input  wire logic signed [EW-1:0] in_elem [mi3inv_pkg::NUM_ELEM],
  output logic                      out_valid,
  output logic signed [EW-1:0]      out_elem [mi3inv_pkg::NUM_ELEM],
  output logic signed [2*EW:0]      out_cof [mi3inv_pkg::NUM_ELEM]
);
  localparam int PW = 2 * EW;

  logic              v1, v2;
  logic signed [EW-1:0] e1 [mi3inv_pkg::NUM_ELEM];
  logic signed [EW-1:0] e2 [mi3inv_pkg::NUM_ELEM];
  logic signed [PW-1:0] pa [mi3inv_pkg::NUM_ELEM];
  logic signed [PW-1:0] pb [mi3inv_pkg::NUM_ELEM];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    e1 <= in_elem;
    e2 <= e1;
    out_elem <= e2;
  end

  for (genvar k = 0; k < mi3inv_pkg::NUM_ELEM; k++) begin : g_cof
    always_ff @(posedge clk) begin
      pa[k] <= e1[mi3inv_pkg::COF_IDX[k][0]] * e1[mi3inv_pkg::COF_IDX[k][1]];
      pb[k] <= e1[mi3inv_pkg::COF_IDX[k][2]] * e1[mi3inv_pkg::COF_IDX[k][3]];
      out_cof[k] <= {pa[k][PW-1], pa[k]} - {pb[k][PW-1], pb[k]};
    end
  end
endmodule
`default_nettype wire

[hdl/mi3inv_det.sv]
`default_nettype none
module mi3inv_det #(
  parameter int EW = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  input  wire logic signed [EW-1:0] in_elem [mi3inv_pkg::NUM_ELEM],
  input  wire logic signed [2*EW:0] in_cof [mi3inv_pkg::NUM_ELEM],
  output logic                      out_valid,
  output logic                      out_singular,
  output logic [3*EW+2:0]           out_dmag,
  output logic [2*EW-1:0]           out_cmag [mi3inv_pkg::NUM_ELEM],
  output logic                      out_qneg [mi3inv_pkg::NUM_ELEM]
);
  localparam int CW = 2 * EW + 1;
  localparam int PW = 2 * EW;
  localparam int DW = 3 * EW + 3;

  logic v4, v5, v6;
  logic signed [CW-1:0] cof4 [mi3inv_pkg::NUM_ELEM];
  logic signed [PW:0]   pp_lo [3];
  logic signed [PW:0]   pp_hi [3];
  logic signed [DW-1:0] term5 [3];
  logic [PW-1:0]        cmag5 [mi3inv_pkg::NUM_ELEM];
  logic [PW-1:0]        cmag6 [mi3inv_pkg::NUM_ELEM];
  logic                 cneg5 [mi3inv_pkg::NUM_ELEM];
  logic                 cneg6 [mi3inv_pkg::NUM_ELEM];
  logic signed [DW-1:0] det6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v4 <= in_valid;
      v5 <= v4;
      v6 <= v5;
      out_valid <= v6;
    end
  end

  // cofactor split into unsigned low half and signed high part
  for (genvar j = 0; j < 3; j++) begin : g_pp
    always_ff @(posedge clk) begin
      pp_lo[j] <= in_elem[j]
                  * $signed({1'b0, in_cof[mi3inv_pkg::DET_COF[j]][EW-1:0]});
      pp_hi[j] <= in_elem[j] * $signed(in_cof[mi3inv_pkg::DET_COF[j]][CW-1:EW]);
      term5[j] <= (DW'(pp_hi[j]) <<< EW) + DW'(pp_lo[j]);
    end
  end

  for (genvar k = 0; k < mi3inv_pkg::NUM_ELEM; k++) begin : g_mag
    always_ff @(posedge clk) begin
      cof4[k]  <= in_cof[k];
      cneg5[k] <= cof4[k][CW-1];
      cmag5[k] <= cof4[k][CW-1] ? PW'(-cof4[k]) : PW'(cof4[k]);
      cneg6[k] <= cneg5[k];
      cmag6[k] <= cmag5[k];
      out_cmag[k] <= cmag6[k];
      out_qneg[k] <= cneg6[k] ^ det6[DW-1];
    end
  end

  always_ff @(posedge clk) begin
    det6 <= term5[0] + term5[1] + term5[2];
    out_dmag <= det6[DW-1] ? DW'(-det6) : DW'(det6);
    out_singular <= (det6 == '0);
  end
endmodule
`default_nettype wire

[hdl/mi3inv_div.sv]
`default_nettype none
module mi3inv_div #(
  parameter int EW = 32,
  parameter int FW = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic [2*EW-1:0]   in_num,
  input  wire logic [3*EW+2:0]   in_den,
  input  wire logic              in_neg,
  output logic                   out_valid,
  output logic [EW-1:0]          out_val,
  output logic                   out_ovf
);
  localparam int DW = 3 * EW + 3;
  localparam int NS = EW + 1;
  localparam int XW = (2 * EW + 2 * FW > DW + EW + 2) ? 2 * EW + 2 * FW : DW + EW + 2;
  localparam int QW = EW + 2;

  logic          st_v   [NS+1];
  logic [XW-1:0] st_r   [NS+1];
  logic [DW-1:0] st_d   [NS+1];
  logic          st_neg [NS+1];
  logic          st_big [NS+1];
  logic [NS-1:0] st_q   [NS+1];

  logic [XW-1:0] num_x;
  logic [QW-1:0] q_rnd, lim, mag;
  logic          sat;

  assign num_x = XW'(in_num) << (2 * FW);

  always_ff @(posedge clk) begin
    if (rst) begin
      st_v[0] <= 1'b0;
    end else begin
      st_v[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    st_r[0]   <= num_x;
    st_d[0]   <= in_den;
    st_neg[0] <= in_neg;
    st_big[0] <= num_x >= (XW'(in_den) << NS);
    st_q[0]   <= '0;
  end

  // one quotient bit per stage, msb first
  for (genvar i = 1; i <= NS; i++) begin : g_step
    localparam int B = NS - i;
    logic [XW-1:0] t;
    assign t = XW'(st_d[i-1]) << B;
    always_ff @(posedge clk) begin
      if (rst) begin
        st_v[i] <= 1'b0;
      end else begin
        st_v[i] <= st_v[i-1];
      end
    end
    always_ff @(posedge clk) begin
      st_d[i]   <= st_d[i-1];
      st_neg[i] <= st_neg[i-1];
      st_big[i] <= st_big[i-1];
      if (st_r[i-1] >= t) begin
        st_r[i] <= st_r[i-1] - t;
        st_q[i] <= st_q[i-1] | (NS'(1) << B);
      end else begin
        st_r[i] <= st_r[i-1];
        st_q[i] <= st_q[i-1];
      end
    end
  end

  // round half up, then clamp
  always_comb begin
    q_rnd = QW'(st_q[NS]) + (((st_r[NS] << 1) >= XW'(st_d[NS])) ? QW'(1) : QW'(0));
    lim   = st_neg[NS] ? (QW'(1) << (EW - 1)) : ((QW'(1) << (EW - 1)) - QW'(1));
    sat   = st_big[NS] || (q_rnd > lim);
    mag   = sat ? lim : q_rnd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= st_v[NS];
    end
  end

  always_ff @(posedge clk) begin
    out_val <= st_neg[NS] ? EW'(-mag) : EW'(mag);
    out_ovf <= sat;
  end
endmodule
`default_nettype wire

[hdl/matrix3x3_inverse_top.sv]
// path: start passes the cofactor, determinant and divider stages, then the output word register, to done
// throughput: one matrix word per cycle, set by the one-bit-per-stage divider lanes
// busy is never raised; done pulses for one cycle per accepted word
// rst (synchronous, active high) clears every valid bit; payload registers hold garbage
`default_nettype none
module matrix3x3_inverse_top #(
  parameter int ELEM_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic signed [ELEM_WIDTH-1:0] in_r0c0,
  input  wire logic signed [ELEM_WIDTH-1:0] in_r0c1,
  input  wire logic signed [ELEM_WIDTH-1:0] in_r0c2,
  input  wire logic signed [ELEM_WIDTH-1:0] in_r1c0,
  input  wire logic signed [ELEM_WIDTH-1:0] in_r1c1,
  input  wire logic signed [ELEM_WIDTH-1:0] in_r1c2,
  input  wire logic signed [ELEM_WIDTH-1:0] in_r2c0,
  input  wire logic signed [ELEM_WIDTH-1:0] in_r2c1,
  input  wire logic signed [ELEM_WIDTH-1:0] in_r2c2,
  output logic                              done,
  output logic signed [ELEM_WIDTH-1:0]      out_r0c0,
  output logic signed [ELEM_WIDTH-1:0]      out_r0c1,
  output logic signed [ELEM_WIDTH-1:0]      out_r0c2,
  output logic signed [ELEM_WIDTH-1:0]      out_r1c0,
  output logic signed [ELEM_WIDTH-1:0]      out_r1c1,
  output logic signed [ELEM_WIDTH-1:0]      out_r1c2,
  output logic signed [ELEM_WIDTH-1:0]      out_r2c0,
  output logic signed [ELEM_WIDTH-1:0]      out_r2c1,
  output logic signed [ELEM_WIDTH-1:0]      out_r2c2,
  output logic                              singular,
  output logic                              overflow
);
`include "matrix3x3_inverse_top_macros.svh"

  localparam int EW  = ELEM_WIDTH;
  localparam int NE  = mi3inv_pkg::NUM_ELEM;
  localparam int DW  = 3 * EW + 3;
  // delay from cofactor outputs to divider outputs, and from det outputs
  localparam int ELD = EW + 7;
  localparam int SGD = EW + 3;

  logic signed [EW-1:0] in_elem [NE];
  logic                 cof_valid;
  logic signed [EW-1:0] cof_elem [NE];
  logic signed [2*EW:0] cof_val [NE];
  logic                 det_valid, det_singular;
  logic [DW-1:0]        det_dmag;
  logic [2*EW-1:0]      det_cmag [NE];
  logic                 det_qneg [NE];
  logic                 div_valid [NE];
  logic [EW-1:0]        div_val [NE];
  logic                 div_ovf [NE];
  logic                 any_ovf;

  // sideband: raw matrix and singular flag ride along with the divider lanes
  logic signed [EW-1:0] elem_dly [ELD][NE];
  logic                 sing_dly [SGD];

  logic signed [EW-1:0] res [NE];
  logic                 sat_seen;

  // the receiver cannot stall, so the pipe never holds anything off
  assign busy = 1'b0;

  assign in_elem[0] = in_r0c0;
  assign in_elem[1] = in_r0c1;
  assign in_elem[2] = in_r0c2;
  assign in_elem[3] = in_r1c0;
  assign in_elem[4] = in_r1c1;
  assign in_elem[5] = in_r1c2;
  assign in_elem[6] = in_r2c0;
  assign in_elem[7] = in_r2c1;
  assign in_elem[8] = in_r2c2;

  // stages 1-3: capture, cofactor products, cofactors
  mi3inv_cof #(.EW(EW)) u_cof (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start && !busy),
    .in_elem   (in_elem),
    .out_valid (cof_valid),
    .out_elem  (cof_elem),
    .out_cof   (cof_val)
  );

  // stages 4-7: determinant, magnitudes and quotient signs
  mi3inv_det #(.EW(EW)) u_det (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (cof_valid),
    .in_elem      (cof_elem),
    .in_cof       (cof_val),
    .out_valid    (det_valid),
    .out_singular (det_singular),
    .out_dmag     (det_dmag),
    .out_cmag     (det_cmag),
    .out_qneg     (det_qneg)
  );

  // nine divider lanes, cofactor * 2^(2*frac) / det
  for (genvar k = 0; k < NE; k++) begin : g_div
    mi3inv_div #(.EW(EW), .FW(FRAC_BITS)) u_div (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (det_valid),
      .in_num    (det_cmag[k]),
      .in_den    (det_dmag),
      .in_neg    (det_qneg[k]),
      .out_valid (div_valid[k]),
      .out_val   (div_val[k]),
      .out_ovf   (div_ovf[k])
    );
  end

  always_ff @(posedge clk) begin
    elem_dly[0] <= cof_elem;
    for (int i = 1; i < ELD; i++) begin
      elem_dly[i] <= elem_dly[i-1];
    end
    sing_dly[0] <= det_singular;
    for (int i = 1; i < SGD; i++) begin
      sing_dly[i] <= sing_dly[i-1];
    end
  end

  always_comb begin
    any_ovf = 1'b0;
    for (int k = 0; k < NE; k++) begin
      any_ovf = any_ovf | div_ovf[k];
    end
  end

  // output word register: a singular matrix goes back unchanged
  always_ff @(posedge clk) begin
    if (rst) begin
      done     <= 1'b0;
      singular <= 1'b0;
      overflow <= 1'b0;
    end else begin
      done     <= div_valid[0];
      singular <= div_valid[0] && sing_dly[SGD-1];
      overflow <= div_valid[0] && !sing_dly[SGD-1] && any_ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (div_valid[0]) begin
      for (int k = 0; k < NE; k++) begin
        res[k] <= sing_dly[SGD-1] ? elem_dly[ELD-1][k] : div_val[k];
      end
    end
  end

  assign out_r0c0 = res[0];
  assign out_r0c1 = res[1];
  assign out_r0c2 = res[2];
  assign out_r1c0 = res[3];
  assign out_r1c1 = res[4];
  assign out_r1c2 = res[5];
  assign out_r2c0 = res[6];
  assign out_r2c1 = res[7];
  assign out_r2c2 = res[8];

  // some element sits at a clamp limit
  always_comb begin
    sat_seen = 1'b0;
    for (int k = 0; k < NE; k++) begin
      sat_seen = sat_seen || (res[k] == {1'b1, {(EW-1){1'b0}}})
                          || (res[k] == {1'b0, {(EW-1){1'b1}}});
    end
  end

  `MI_ASSERT_NOW(a_sing_no_ovf, done && singular, !overflow, "overflow on singular word")
  `MI_ASSERT_NOW(a_flags_idle, !done, !singular && !overflow, "flags without done")
  `MI_ASSERT_NOW(a_ovf_clamped, done && overflow, sat_seen, "overflow but no clamped element")
endmodule
`default_nettype wire
